// File: src/jtcp_pkg.sv
// Shared types, constants and TAP tables for the JTAG TAP command planner.
package jtcp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_PHASES  = 5;
    localparam int PAT_W       = 7;

    typedef logic [3:0]             tap_st_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [PAT_W-1:0]       tms_pat_t;
    typedef logic [2:0]             path_len_t;
    typedef logic [2:0]             stable_idx_t;

    localparam tap_st_t ST_RESET   = 4'd0;
    localparam tap_st_t ST_IDLE    = 4'd1;
    localparam tap_st_t ST_DRSHIFT = 4'd4;
    localparam tap_st_t ST_DRPAUSE = 4'd6;
    localparam tap_st_t ST_IRSHIFT = 4'd11;
    localparam tap_st_t ST_IRPAUSE = 4'd13;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_SCAN = 1'b1;
    localparam logic SEG_TMS  = 1'b0;
    localparam logic SEG_DATA = 1'b1;

    typedef struct packed {
        logic       command;
        tap_st_t    end_state;
        logic       ir_scan;
        count_t     scan_bits;
        logic       last_tdi;
        logic       capture_tdo;
    } cmd_item_t;

    typedef struct packed {
        logic       segment_kind;
        tms_pat_t   tms_pattern;
        count_t     shift_count;
        logic       tdi_level;
        logic       sample_tdo;
        tap_st_t    state_after;
        logic       last;
    } seg_item_t;

    // Command as classified by the front end
    typedef struct packed {
        logic       is_scan;
        tap_st_t    goal;
        tap_st_t    shift_st;
        logic       has_data;
        logic       has_exit;
        logic       go_idle;
        logic       final_move;
        count_t     data_count;
        logic       tdi;
        logic       cap;
    } plan_t;

    typedef enum logic [2:0] {
        PH_SHIFT_MOVE = 3'd0,
        PH_DATA       = 3'd1,
        PH_EXIT       = 3'd2,
        PH_TAIL       = 3'd3,
        PH_GOAL_MOVE  = 3'd4
    } phase_t;

    localparam tap_st_t NEXT_TMS0 [16] = '{
        4'd1, 4'd1, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4,
        4'd1, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd11, 4'd1
    };
    localparam tap_st_t NEXT_TMS1 [16] = '{
        4'd0, 4'd2, 4'd9, 4'd5, 4'd5, 4'd8, 4'd7, 4'd8,
        4'd2, 4'd0, 4'd12, 4'd12, 4'd15, 4'd14, 4'd15, 4'd2
    };
    localparam stable_idx_t STABLE_IDX [16] = '{
        3'd0, 3'd1, 3'd0, 3'd0, 3'd2, 3'd0, 3'd3, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd5, 3'd0, 3'd0
    };
    localparam logic [7:0] PATH_BITS [6][6] = '{
        '{8'hff, 8'h00, 8'h17, 8'h0A, 8'h1B, 8'h16},
        '{8'hff, 8'h00, 8'h01, 8'h05, 8'h03, 8'h0B},
        '{8'hff, 8'h03, 8'h07, 8'h01, 8'h0F, 8'h2F},
        '{8'hff, 8'h03, 8'h01, 8'h00, 8'h0F, 8'h2F},
        '{8'hff, 8'h03, 8'h07, 8'h17, 8'h01, 8'h01},
        '{8'hff, 8'h03, 8'h07, 8'h17, 8'h01, 8'h00}
    };
    localparam path_len_t PATH_LEN [6][6] = '{
        '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
        '{3'd7, 3'd7, 3'd3, 3'd4, 3'd4, 3'd5},
        '{3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd7},
        '{3'd7, 3'd3, 3'd2, 3'd1, 3'd6, 3'd7},
        '{3'd7, 3'd3, 3'd5, 3'd6, 3'd2, 3'd2},
        '{3'd7, 3'd3, 3'd5, 3'd6, 3'd2, 3'd1}
    };

    // Follow up to seven TMS bits through the TAP graph
    function automatic tap_st_t tap_walk(tap_st_t s, tms_pat_t pat, path_len_t len);
        tap_st_t cur;
        cur = s;
        for (int i = 0; i < PAT_W; i++) begin
            if (3'(i) < len)
            begin
                cur = pat[i] ? NEXT_TMS1[cur] : NEXT_TMS0[cur];
            end
        end
        return cur;
    endfunction

endpackage

// File: src/jtcp_front.sv
// Front end: takes commands, classifies them and queues the plans.
module jtcp_front
    import jtcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  cmd_item_t cmd,
    output logic      plan_valid,
    output plan_t     plan,
    input  logic      plan_pop
);

    plan_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;
    plan_t                  cls;
    tap_st_t                pre_goal;
    logic                   accept;
    logic                   take;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign plan_valid = (cnt_reg != '0);
    assign plan       = entry_reg[rd_ptr_reg];
    assign accept     = push && !full;
    assign take       = plan_pop && plan_valid;

    // Everything about a scan that does not depend on the live TAP state
    always_comb
    begin
        cls.is_scan    = (cmd.command == CMD_SCAN);
        cls.goal       = cmd.end_state;
        cls.shift_st   = cmd.ir_scan ? ST_IRSHIFT : ST_DRSHIFT;
        cls.has_exit   = (cmd.scan_bits != '0);
        cls.has_data   = |cmd.scan_bits[COUNT_WIDTH-1:1];
        cls.go_idle    = (cmd.end_state == ST_IDLE);
        cls.data_count = cmd.scan_bits - count_t'(1);
        cls.tdi        = cmd.last_tdi;
        cls.cap        = cmd.capture_tdo;
        if (!cls.has_exit)
        begin
            pre_goal = cls.shift_st;
        end
        else if (cls.go_idle)
        begin
            pre_goal = ST_IDLE;
        end
        else
        begin
            pre_goal = cmd.ir_scan ? ST_IRPAUSE : ST_DRPAUSE;
        end
        cls.final_move = (pre_goal != cmd.end_state);
    end

    always_comb
    begin
        wr_ptr_next = accept ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = take ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = QCNT_W'(cnt_reg + QCNT_W'(accept) - QCNT_W'(take));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue empty but pointers differ");

    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !take |=> cnt_reg == $past(cnt_reg) + QCNT_W'(1))
        else $error("queue count did not grow on a transfer in");

endmodule

// File: src/jtcp_back.sv
// Back end: owns the TAP state, emits plan segments one per cycle unless stalled.
module jtcp_back
    import jtcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      plan_valid,
    input  plan_t     plan,
    output logic      plan_pop,
    output logic      empty,
    input  logic      pop,
    output seg_item_t seg
);

    tap_st_t                 tap_state_reg, tap_state_next;
    phase_t                  phase_reg, phase_next;
    logic                    out_valid_reg, out_valid_next;
    seg_item_t               seg_reg, seg_next;
    logic [NUM_PHASES-1:0]   flags;
    logic [NUM_PHASES-1:0]   low;
    logic                    any_seg;
    logic                    is_last;
    logic                    go;
    phase_t                  sel_phase;
    tap_st_t                 target;
    stable_idx_t             idx_a, idx_b;
    logic [7:0]              mv_bits;
    path_len_t               mv_len;
    tap_st_t                 mv_state;

    assign empty = !out_valid_reg;
    assign seg   = seg_reg;
    assign go    = plan_valid && (!out_valid_reg || pop);

    // Which segments are still due for the plan at the head of the queue
    always_comb
    begin
        flags = '0;
        flags[int'(PH_SHIFT_MOVE)] = plan.is_scan && (phase_reg == PH_SHIFT_MOVE)
                                     && (tap_state_reg != plan.shift_st);
        flags[int'(PH_DATA)]       = plan.is_scan && plan.has_data && (phase_reg <= PH_DATA);
        flags[int'(PH_EXIT)]       = plan.is_scan && plan.has_exit && (phase_reg <= PH_EXIT);
        flags[int'(PH_TAIL)]       = plan.is_scan && plan.has_exit && (phase_reg <= PH_TAIL);
        if (plan.is_scan)
        begin
            flags[int'(PH_GOAL_MOVE)] = plan.final_move;
        end
        else
        begin
            flags[int'(PH_GOAL_MOVE)] = (tap_state_reg != plan.goal) || (plan.goal == ST_RESET);
        end
        low     = flags & NUM_PHASES'(~flags + 1'b1);
        any_seg = (flags != '0);
        is_last = ((flags & ~low) == '0);
        sel_phase = PH_GOAL_MOVE;
        for (int i = NUM_PHASES - 1; i >= 0; i--) begin
            if (low[i])
            begin
                sel_phase = phase_t'(3'(i));
            end
        end
    end

    // Shared path lookup for both move segments
    always_comb
    begin
        target   = (sel_phase == PH_SHIFT_MOVE) ? plan.shift_st : plan.goal;
        idx_a    = STABLE_IDX[tap_state_reg];
        idx_b    = STABLE_IDX[target];
        mv_bits  = PATH_BITS[idx_a][idx_b];
        mv_len   = PATH_LEN[idx_a][idx_b];
        mv_state = tap_walk(tap_state_reg, mv_bits[PAT_W-1:0], mv_len);
    end

    // Next state of the segment sequencer
    always_comb
    begin
        phase_next = phase_reg;
        plan_pop   = 1'b0;
        if (go)
        begin
            if (!any_seg || is_last)
            begin
                phase_next = PH_SHIFT_MOVE;
                plan_pop   = 1'b1;
            end
            else
            begin
                phase_next = phase_t'(sel_phase + 3'd1);
            end
        end
    end

    // Segment contents
    always_comb
    begin
        seg_next.segment_kind = SEG_TMS;
        seg_next.tms_pattern  = '0;
        seg_next.shift_count  = '0;
        seg_next.tdi_level    = 1'b0;
        seg_next.sample_tdo   = 1'b0;
        seg_next.state_after  = tap_state_reg;
        seg_next.last         = is_last;
        unique case (sel_phase) inside
            PH_SHIFT_MOVE, PH_GOAL_MOVE:
            begin
                seg_next.tms_pattern = mv_bits[PAT_W-1:0];
                seg_next.shift_count = COUNT_WIDTH'(mv_len);
                seg_next.state_after = mv_state;
            end
            PH_DATA:
            begin
                seg_next.segment_kind = SEG_DATA;
                seg_next.shift_count  = plan.data_count;
                seg_next.sample_tdo   = plan.cap;
            end
            PH_EXIT:
            begin
                seg_next.tms_pattern = tms_pat_t'(1);
                seg_next.shift_count = count_t'(1);
                seg_next.tdi_level   = plan.tdi;
                seg_next.sample_tdo  = plan.cap;
                seg_next.state_after = NEXT_TMS1[tap_state_reg];
            end
            PH_TAIL:
            begin
                seg_next.tdi_level = plan.tdi;
                if (plan.go_idle)
                begin
                    // TMS 1 then 0: update, then idle
                    seg_next.tms_pattern = tms_pat_t'(1);
                    seg_next.shift_count = count_t'(2);
                    seg_next.state_after = NEXT_TMS0[NEXT_TMS1[tap_state_reg]];
                end
                else
                begin
                    seg_next.shift_count = count_t'(1);
                    seg_next.state_after = NEXT_TMS0[tap_state_reg];
                end
            end
            default:
            begin
                seg_next.last = is_last;
            end
        endcase
    end

    always_comb
    begin
        tap_state_next = tap_state_reg;
        out_valid_next = out_valid_reg && !pop;
        if (go && any_seg)
        begin
            tap_state_next = seg_next.state_after;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_state_reg <= ST_RESET;
            phase_reg     <= PH_SHIFT_MOVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tap_state_reg <= tap_state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && any_seg)
        begin
            seg_reg <= seg_next;
        end
    end

    a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        go && any_seg |=> tap_state_reg == seg_reg.state_after)
        else $error("TAP state does not match the last segment");

    a_data_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seg_reg.segment_kind == SEG_DATA |->
        (seg_reg.state_after == ST_DRSHIFT || seg_reg.state_after == ST_IRSHIFT))
        else $error("data segment outside a shift state");

    a_phase_needs_plan: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SHIFT_MOVE |-> plan_valid)
        else $error("sequencer mid-command with no plan queued");

endmodule

// File: src/jtag_tap_command_planner.sv
// Top level of the JTAG TAP command planner.
//
// Commands enter through a queue-style port: cmd is taken at a rising edge
// with push high and full low. Each command turns into zero to five pin-level
// segments (TMS paths, a data shift, the exit bit, the idle or pause step and
// the final move), read out oldest first: seg is valid while empty is low and
// is transferred at an edge with pop high and empty low.
// A two-entry command queue sits between the front end, which classifies each
// command, and the back end, which owns the TAP state and emits segments.
// A command is registered in the command queue, and its first segment then in the
// output register once the back end is free. The back end emits one segment
// per cycle while it advances; a command that yields no segment is taken off
// the queue without one. The back end advances only while the output register
// is empty or being popped; when pop stays low the output holds and the command
// queue keeps taking commands until it fills.
// Reset sets the TAP state to test logic reset and empties queue and output register.
module jtag_tap_command_planner
    import jtcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  cmd_item_t cmd,
    output logic      empty,
    input  logic      pop,
    output seg_item_t seg
);

    plan_t plan;
    logic  plan_valid;
    logic  plan_pop;

    jtcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_pop   (plan_pop)
    );

    jtcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_pop   (plan_pop),
        .empty      (empty),
        .pop        (pop),
        .seg        (seg)
    );

endmodule
